### src/sorted_timer_event_queue_core_macros.svh
// Assertion macros for the sorted timer event queue
`ifndef SORTED_TIMER_EVENT_QUEUE_CORE_MACROS_SVH
`define SORTED_TIMER_EVENT_QUEUE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define STQC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define STQC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/stqc_pkg.sv
// Shared types, constants and ordering function for the sorted timer event queue
package stqc_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY  = 1'b0,
        REG_ASCENDING = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [63:0] tm;
        logic [31:0]        seq;
        logic [31:0]        cb;
        logic [31:0]        arg;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        logic   asc;
        entry_t ins;
    } cmd_t;

    // true when a is placed before b under the selected order
    function automatic logic precedes(entry_t a, entry_t b, logic asc);
        logic [31:0] d;
        logic        r;
        d = a.seq - b.seq;
        if (asc)
        begin
            r = (a.tm != b.tm) ? (a.tm < b.tm) : d[31];
        end
        else
        begin
            r = (a.tm != b.tm) ? (a.tm > b.tm) : ((d != 32'd0) && !d[31]);
        end
        return r;
    endfunction

endpackage

### src/stqc_if.sv
// Request, response and configuration channel interfaces
interface stqc_req_if;
    import stqc_pkg::*;
    logic               valid;
    logic               ready;
    op_t                op;
    logic signed [63:0] event_time;
    logic [31:0]        callback_handle;
    logic [31:0]        argument_handle;
    logic [IDX_W-1:0]   index;

    modport source (output valid, op, event_time, callback_handle, argument_handle, index,
                    input ready);
    modport sink   (input valid, op, event_time, callback_handle, argument_handle, index,
                    output ready);
endinterface

interface stqc_rsp_if;
    import stqc_pkg::*;
    logic               valid;
    logic               ready;
    status_t            status;
    logic signed [63:0] event_time_res;
    logic [31:0]        callback_handle_res;
    logic [31:0]        argument_handle_res;
    logic [CNT_W-1:0]   count;

    modport source (output valid, status, event_time_res, callback_handle_res,
                           argument_handle_res, count,
                    input ready);
    modport sink   (input valid, status, event_time_res, callback_handle_res,
                          argument_handle_res, count,
                    output ready);
endinterface

interface stqc_cfg_if;
    import stqc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/stqc_cell.sv
// One compare-and-shift cell of the sorted entry row
module stqc_cell (
    input  logic           clk,
    input  stqc_pkg::cmd_t cmd,
    input  logic           occ,
    input  logic           at_tail,
    input  logic           found_in,
    input  stqc_pkg::entry_t left,
    input  stqc_pkg::entry_t right,
    output stqc_pkg::entry_t entry,
    output logic           found_out
);
    import stqc_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;

    assign hit       = occ && precedes(cmd.ins, entry_reg, cmd.asc);
    assign found_out = found_in || hit;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.push)
        begin
            if (found_in && (occ || at_tail))
            begin
                entry_next = left;
            end
            else if (!found_in && (hit || at_tail))
            begin
                entry_next = cmd.ins;
            end
        end
        else if (cmd.pop)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### src/sorted_timer_event_queue_core.sv
// Sorted timer event queue: requests go through a row of compare-and-shift cells,
// the result is registered in the cycle after the transfer and held in an output
// register; a new request is taken whenever that register is empty or being drained,
// so throughput is one operation per cycle, set by the insert and shift of the cell row.
module sorted_timer_event_queue_core (
    input logic clk,
    input logic rst_n,
    stqc_req_if.sink   req,
    stqc_rsp_if.source rsp,
    stqc_cfg_if.sink   cfg
);
    import stqc_pkg::*;

    `include "sorted_timer_event_queue_core_macros.svh"

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      seq_reg;
    logic [CFG_W-1:0] cap_reg;
    logic             asc_reg;
    logic             rsp_valid_reg;
    status_t          st_reg, st_next;
    entry_t           res_reg, res_next;
    logic [CNT_W-1:0] rcnt_reg;

    logic             fire, full, push_ok, pop_ok;
    logic [CNT_W-1:0] limit;
    cmd_t             cmd;
    entry_t           cells [DEPTH];
    logic [DEPTH:0]   found;

    assign fire      = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    assign limit   = (cap_reg < CNT_W'(DEPTH)) ? cap_reg : CNT_W'(DEPTH);
    assign full    = cnt_reg >= limit;
    assign push_ok = fire && (req.op == OP_PUSH) && !full;
    assign pop_ok  = fire && (req.op == OP_POP) && (cnt_reg != '0);

    assign cmd.push    = push_ok;
    assign cmd.pop     = pop_ok;
    assign cmd.asc     = asc_reg;
    assign cmd.ins.tm  = req.event_time;
    assign cmd.ins.seq = seq_reg;
    assign cmd.ins.cb  = req.callback_handle;
    assign cmd.ins.arg = req.argument_handle;

    assign found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            stqc_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .occ       (CNT_W'(g) < cnt_reg),
                .at_tail   (CNT_W'(g) == cnt_reg),
                .found_in  (found[g]),
                .left      ((g == 0) ? cmd.ins : cells[(g == 0) ? 0 : g - 1]),
                .right     (cells[(g == DEPTH - 1) ? g : g + 1]),
                .entry     (cells[g]),
                .found_out (found[g + 1])
            );
        end
    endgenerate

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push_ok)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        st_next  = ST_OK;
        res_next = '0;
        unique case (req.op)
            OP_PUSH:
            begin
                if (full)
                begin
                    st_next = ST_OVERFLOW;
                end
            end
            OP_POP:
            begin
                if (cnt_reg == '0)
                begin
                    st_next = ST_EMPTY;
                end
                else
                begin
                    res_next = cells[0];
                end
            end
            OP_PEEK:
            begin
                if (cnt_reg == '0)
                begin
                    st_next = ST_EMPTY;
                end
                else if ({1'b0, req.index} >= cnt_reg)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    res_next = cells[req.index];
                end
            end
            OP_STATUS:
            begin
                st_next = ST_OK;
            end
            default:
            begin
                st_next = ST_OK;
            end
        endcase
        res_next.seq = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            seq_reg       <= '0;
            cap_reg       <= CFG_W'(DEPTH);
            asc_reg       <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push_ok)
            begin
                seq_reg <= seq_reg + 32'd1;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                unique case (reg_idx_t'(cfg.index))
                    REG_CAPACITY:  cap_reg <= cfg.data;
                    REG_ASCENDING: asc_reg <= cfg.data[0];
                    default:       cap_reg <= cap_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            st_reg   <= st_next;
            res_reg  <= res_next;
            rcnt_reg <= cnt_next;
        end
    end

    assign rsp.valid               = rsp_valid_reg;
    assign rsp.status              = st_reg;
    assign rsp.event_time_res      = res_reg.tm;
    assign rsp.callback_handle_res = res_reg.cb;
    assign rsp.argument_handle_res = res_reg.arg;
    assign rsp.count               = rcnt_reg;

    `STQC_ASSERT_NEXT(a_push_grows, push_ok, cnt_reg == $past(cnt_reg) + CNT_W'(1),
        "push did not grow the count")
    `STQC_ASSERT_NEXT(a_pop_shrinks, pop_ok, cnt_reg == $past(cnt_reg) - CNT_W'(1),
        "pop did not shrink the count")
    `STQC_ASSERT_NEXT(a_read_keeps, fire && (req.op == OP_PEEK || req.op == OP_STATUS),
        $stable(cnt_reg) && $stable(seq_reg), "peek or status changed queue state")
    `STQC_ASSERT_NEXT(a_fire_result, fire, rsp.valid && rsp.count == cnt_reg,
        "transfer gave no result or a stale count")
    `STQC_ASSERT_NOW(a_count_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH),
        "count beyond depth")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted timer event queue core
module testbench;
    import stqc_pkg::*;

    localparam logic signed [63:0] T_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] T_MIN = {1'b1, {63{1'b0}}};
    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 80;

    typedef struct packed {
        op_t                op;
        logic signed [63:0] tm;
        logic [31:0]        cb;
        logic [31:0]        arg;
        logic [IDX_W-1:0]   idx;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic signed [63:0] tm;
        logic [31:0]        cb;
        logic [31:0]        arg;
        logic [CNT_W-1:0]   count;
    } reply_t;

    logic clk;
    logic rst_n;

    stqc_req_if req_ch ();
    stqc_rsp_if rsp_ch ();
    stqc_cfg_if cfg_ch ();

    sorted_timer_event_queue_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // shadow of the event queue
    logic signed [63:0] slot_tm  [DEPTH];
    logic [31:0]        slot_seq [DEPTH];
    logic [31:0]        slot_cb  [DEPTH];
    logic [31:0]        slot_arg [DEPTH];
    int                 held_events    = 0;
    logic [31:0]        seq_counter    = 32'd0;
    logic [CFG_W-1:0]   capacity_limit = 5'd16;
    logic               earliest_first = 1'b1;

    request_t request_backlog[$];
    reply_t   outstanding_replies[$];
    request_t on_bus;
    int       requests_issued = 0;
    int       requests_taken  = 0;
    int       mismatches      = 0;
    bit       idling          = 1'b1;
    int       send_gap        = 0;
    int       hold_left       = 0;
    int       hold_asks       = 0;
    int       holds_done      = 0;
    int       quiet_cycles    = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic goes_ahead(logic signed [63:0] tm, logic [31:0] seq, int i);
        logic [31:0] age;
        age = seq - slot_seq[i];
        if (tm != slot_tm[i])
            return earliest_first ? (tm < slot_tm[i]) : (tm > slot_tm[i]);
        if (earliest_first)
            return age[31];
        return (age != 32'd0) && !age[31];
    endfunction

    function automatic reply_t timer_queue_apply(request_t r);
        reply_t y;
        int     lim;
        int     pos;
        int     i;
        y = '0;
        y.status = ST_OK;
        lim = (capacity_limit < DEPTH) ? int'(capacity_limit) : DEPTH;
        case (r.op)
            OP_PUSH:
            begin
                if (held_events >= lim)
                begin
                    y.status = ST_OVERFLOW;
                end
                else
                begin
                    pos = held_events;
                    for (i = 0; i < held_events; i++)
                    begin
                        if (goes_ahead(r.tm, seq_counter, i))
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = held_events; i > pos; i--)
                    begin
                        slot_tm[i]  = slot_tm[i-1];
                        slot_seq[i] = slot_seq[i-1];
                        slot_cb[i]  = slot_cb[i-1];
                        slot_arg[i] = slot_arg[i-1];
                    end
                    slot_tm[pos]  = r.tm;
                    slot_seq[pos] = seq_counter;
                    slot_cb[pos]  = r.cb;
                    slot_arg[pos] = r.arg;
                    seq_counter++;
                    held_events++;
                end
            end
            OP_POP:
            begin
                if (held_events == 0)
                begin
                    y.status = ST_EMPTY;
                end
                else
                begin
                    y.tm  = slot_tm[0];
                    y.cb  = slot_cb[0];
                    y.arg = slot_arg[0];
                    for (i = 1; i < held_events; i++)
                    begin
                        slot_tm[i-1]  = slot_tm[i];
                        slot_seq[i-1] = slot_seq[i];
                        slot_cb[i-1]  = slot_cb[i];
                        slot_arg[i-1] = slot_arg[i];
                    end
                    held_events--;
                end
            end
            OP_PEEK:
            begin
                if (held_events == 0)
                    y.status = ST_EMPTY;
                else if (int'(r.idx) >= held_events)
                    y.status = ST_RANGE;
                else
                begin
                    y.tm  = slot_tm[r.idx];
                    y.cb  = slot_cb[r.idx];
                    y.arg = slot_arg[r.idx];
                end
            end
            default:
            begin
            end
        endcase
        y.count = CNT_W'(held_events);
        return y;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                outstanding_replies.push_back(timer_queue_apply(on_bus));
                requests_taken++;
            end
            if (req_ch.valid && !req_ch.ready)
            begin
                // hold the offered request
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (request_backlog.size() > 0)
            begin
                on_bus = request_backlog.pop_front();
                req_ch.valid           <= 1'b1;
                req_ch.op              <= on_bus.op;
                req_ch.event_time      <= on_bus.tm;
                req_ch.callback_handle <= on_bus.cb;
                req_ch.argument_handle <= on_bus.arg;
                req_ch.index           <= on_bus.idx;
                if (idling && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 11);
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (outstanding_replies.size() == 0)
                begin
                    $error("response transfer with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = outstanding_replies.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.event_time_res !== want.tm)
                    begin
                        $error("event_time_res: expected %0d, actual %0d",
                               want.tm, rsp_ch.event_time_res);
                        mismatches++;
                    end
                    if (rsp_ch.callback_handle_res !== want.cb)
                    begin
                        $error("callback_handle_res: expected %h, actual %h",
                               want.cb, rsp_ch.callback_handle_res);
                        mismatches++;
                    end
                    if (rsp_ch.argument_handle_res !== want.arg)
                    begin
                        $error("argument_handle_res: expected %h, actual %h",
                               want.arg, rsp_ch.argument_handle_res);
                        mismatches++;
                    end
                    if (rsp_ch.count !== want.count)
                    begin
                        $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
                        mismatches++;
                    end
                end
            end
            if (hold_asks != holds_done)
            begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 10);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("sorted_timer_event_queue_core: mismatch");
            $finish;
        end
    end

    task automatic enqueue(op_t op, logic signed [63:0] tm, logic [31:0] cb, logic [31:0] arg,
                           logic [IDX_W-1:0] idx);
        request_t r;
        r.op  = op;
        r.tm  = tm;
        r.cb  = cb;
        r.arg = arg;
        r.idx = idx;
        request_backlog.push_back(r);
        requests_issued++;
    endtask

    function automatic logic signed [63:0] pick_time();
        logic signed [63:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: v = T_MAX;
                    1: v = T_MIN;
                    2: v = T_MAX - 1;
                    3: v = T_MIN + 1;
                    4: v = 64'sd0;
                    default: v = -64'sd1;
                endcase
            end
            1, 2, 3, 4:
            begin
                v = 64'($urandom_range(0, 16));
                v = v - 64'sd8;
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic enqueue_random(int push_pct);
        logic [IDX_W-1:0] idx;
        op_t              op;
        idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 3))
                                   : IDX_W'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < push_pct)
            op = OP_PUSH;
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: op = OP_POP;
                6, 7, 8: op = OP_PEEK;
                default: op = OP_STATUS;
            endcase
        end
        enqueue(op, pick_time(), pick_word(), pick_word(), idx);
    endtask

    task automatic write_reg(reg_idx_t which, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= which;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (which == REG_CAPACITY)
            capacity_limit = value;
        else
            earliest_first = value[0];
    endtask

    task automatic settle();
        while (requests_taken != requests_issued || outstanding_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int         phase_items [8];
        int         phase;
        int         n;
        int         push_pct;
        logic [4:0] cap;
        logic [3:0] pad;
        logic       order;

        phase_items            = '{220, 120, 80, 150, 220, 220, 220, 250};
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.op              = OP_STATUS;
        req_ch.event_time      = '0;
        req_ch.callback_handle = '0;
        req_ch.argument_handle = '0;
        req_ch.index           = '0;
        rsp_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_CAPACITY;
        cfg_ch.data            = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_CAPACITY, 5'd4);
        enqueue(OP_STATUS, '1, '1, '1, '1);
        enqueue(OP_POP, 0, 0, 0, 0);
        enqueue(OP_PEEK, 0, 0, 0, 0);
        enqueue(OP_PUSH, 64'sd0, '1, 32'd0, 0);
        enqueue(OP_PUSH, T_MAX, 32'd0, '1, 0);
        enqueue(OP_PUSH, T_MIN, 32'h1234_5678, 32'h9abc_def0, 0);
        enqueue(OP_PUSH, 64'sd0, 32'd5, 32'd6, 0);
        enqueue(OP_PUSH, -64'sd1, 32'd7, 32'd8, 0);
        enqueue(OP_PEEK, 0, 0, 0, 4'd15);
        enqueue(OP_PEEK, 0, 0, 0, 4'd3);
        enqueue(OP_PEEK, 0, 0, 0, 4'd4);
        repeat (4) enqueue(OP_POP, 0, 0, 0, 0);
        enqueue(OP_POP, 0, 0, 0, 0);
        settle();

        write_reg(REG_ASCENDING, 5'd0);
        enqueue(OP_PUSH, 64'sd5, 32'hA, 32'hA, 0);
        enqueue(OP_PUSH, 64'sd5, 32'hB, 32'hB, 0);
        enqueue(OP_PUSH, T_MAX, 32'hC, 32'hC, 0);
        enqueue(OP_PUSH, T_MIN, 32'hD, 32'hD, 0);
        enqueue(OP_PEEK, 0, 0, 0, 4'd1);
        repeat (4) enqueue(OP_POP, 0, 0, 0, 0);
        settle();

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: cap = 5'd16;
                1: cap = 5'd1;
                2: cap = 5'd0;
                3: cap = 5'd31;
                4: cap = 5'($urandom_range(2, 15));
                6: cap = 5'($urandom_range(1, 16));
                default: cap = 5'd16;
            endcase
            order = phase[0];
            pad   = 4'($urandom_range(0, 15));
            idling = (phase != 7);
            write_reg(REG_CAPACITY, cap);
            write_reg(REG_ASCENDING, {pad, order});
            push_pct = 70;
            for (n = 0; n < phase_items[phase]; n++)
            begin
                if (n % 24 == 0)
                    push_pct = $urandom_range(0, 1) ? 70 : 30;
                enqueue_random(push_pct);
            end
            if (phase == 3 || phase == 6)
                hold_asks++;
            settle();
        end

        if (mismatches == 0)
            $display("sorted_timer_event_queue_core: match");
        else
            $display("sorted_timer_event_queue_core: mismatch");
        $finish;
    end
endmodule
